// ===== src/apan_pkg.sv =====
// Package for the alarm annunciator panel: widths, reset values and shared types.
`default_nettype none
package apan_pkg;

  // Detector channels in use (1..10; the alarm_lines field is 10 bits wide)
  localparam int ChanCount = 10;
  localparam int LineW     = 10;
  localparam int ChanW     = 4;
  localparam int PosW      = 4;
  localparam int LimitW    = 8;
  localparam int InDataW   = 16;
  localparam int OutDataW  = 16;

  localparam logic [LimitW-1:0] DebounceLimitReset = LimitW'(50);
  localparam logic [LimitW-1:0] ElapsedMax         = {LimitW{1'b1}};

  // Lines that are actually wired to detectors
  localparam logic [LineW-1:0] LineMask = LineW'((11'(1) << ChanCount) - 11'(1));

  // One main-loop sample
  typedef struct packed {
    logic             display_tick;
    logic             ms_tick;
    logic             button_level;
    logic [LineW-1:0] alarm_lines;
  } apan_in_t;

  // One panel result
  typedef struct packed {
    logic [ChanW-1:0] display_channel;
    logic             display_silent_tag;
    logic             display_has_channel;
    logic             display_update;
    logic             yellow_led;
    logic             red_led;
    logic             relay_on;
  } apan_out_t;

  // Display selection handed back from the rotation logic
  typedef struct packed {
    logic             has_channel;
    logic [ChanW-1:0] channel;
    logic [PosW-1:0]  pos_next;
  } apan_disp_t;

endpackage : apan_pkg
`default_nettype wire

// ===== src/apan_display.sv =====
// Display rotation: picks the next latched channel in ascending order.
`default_nettype none
module apan_display (
  input  wire logic [apan_pkg::LineW-1:0] latched,
  input  wire logic [apan_pkg::PosW-1:0]  pos,
  output apan_pkg::apan_disp_t            sel
);
  import apan_pkg::*;

  logic [LineW-1:0] hit;
  logic [LineW-1:0] low_hit;
  logic [LineW-1:0] pick;
  logic [PosW-1:0]  pos_used;
  logic [PosW:0]    pos_inc;
  logic [PosW:0]    cnt;

  // One compare per channel: is this the pos-th latched channel?
  always_comb begin
    for (int i = 0; i < LineW; i++) begin
      hit[i] = latched[i] &&
               (PosW'($countones(latched & LineW'((11'(1) << i) - 11'(1)))) == pos);
    end
  end

  // Lowest latched channel, used when pos points past the list
  assign low_hit  = latched & (~latched + LineW'(1));
  assign pick     = (|hit) ? hit : low_hit;
  assign pos_used = (|hit) ? pos : '0;
  assign cnt      = (PosW+1)'($countones(latched));
  assign pos_inc  = {1'b0, pos_used} + (PosW+1)'(1);

  // Encode the one-hot pick
  always_comb begin
    sel.channel = '0;
    for (int i = 0; i < LineW; i++) begin
      if (pick[i]) begin
        sel.channel = ChanW'(i);
      end
    end
    sel.has_channel = |latched;
    sel.pos_next    = (pos_inc >= cnt) ? '0 : pos_inc[PosW-1:0];
  end

endmodule : apan_display
`default_nettype wire

// ===== src/apan_debounce.sv =====
// Button debounce: times a press from its last falling edge, flags a silence toggle.
`default_nettype none
module apan_debounce (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        button_level,
  input  wire logic                        ms_tick,
  input  wire logic [apan_pkg::LimitW-1:0] limit,
  output logic                             toggle
);
  import apan_pkg::*;

  logic              button_previous;
  logic              active;
  logic              active_next;
  logic [LimitW-1:0] elapsed;
  logic [LimitW-1:0] elapsed_next;
  logic              act_mid;

  // Restart on falling edge, otherwise count ticks with saturation
  always_comb begin
    act_mid      = active;
    elapsed_next = elapsed;
    if (button_previous && !button_level) begin
      act_mid      = 1'b1;
      elapsed_next = '0;
    end else if (active && ms_tick && (elapsed != ElapsedMax)) begin
      elapsed_next = elapsed + LimitW'(1);
    end
    active_next = act_mid;
    toggle      = 1'b0;
    if (act_mid && (elapsed_next > limit)) begin
      active_next = 1'b0;
      toggle      = !button_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_previous <= 1'b1;
      active          <= 1'b0;
      elapsed         <= '0;
    end else if (en) begin
      button_previous <= button_level;
      active          <= active_next;
      elapsed         <= elapsed_next;
    end
  end

endmodule : apan_debounce
`default_nettype wire

// ===== src/alarm_annunciator_panel.sv =====
// Alarm annunciator panel top level: input register, panel logic, result register.
//
// Input stream s_axis carries one main-loop sample per transaction: alarm
// lines, button level, millisecond tick and display refresh flag. Output
// stream m_axis returns exactly one panel result per input transaction:
// relay drive, LEDs and the display entry to show.
// A sample is held in the input register; the panel state is updated
// as it moves into the result register, whose output drives m_axis.
// Throughput is one transaction per cycle while m_axis does not stall;
// every path is a single pass over the ten channels between the two
// registers.
// When m_axis stalls, the result register holds, the input register fills,
// and s_axis_tready drops; nothing is lost or repeated.
// cfg_wen writes the debounce limit (milliseconds) from cfg_wdata; write it
// only while the panel is idle.
// Reset (rst, synchronous) empties both registers, clears latched channels,
// the sticky alarm and the silence state, and sets the limit to 50 ms.
`default_nettype none
module alarm_annunciator_panel (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wen,
  input  wire logic [apan_pkg::LimitW-1:0]    cfg_wdata,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [9:0] alarm_lines, [10] button_level, [11] ms_tick, [12] display_tick
  input  wire logic [apan_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [0] relay_on, [1] red_led, [2] yellow_led, [3] display_update,
  // [4] display_has_channel, [5] display_silent_tag, [9:6] display_channel
  output logic [apan_pkg::OutDataW-1:0]       m_axis_tdata
);
  import apan_pkg::*;

  localparam int InW  = $bits(apan_in_t);

  logic              in_valid;
  apan_in_t          in_item;
  logic              out_valid;
  apan_out_t         out_item;
  apan_out_t         out_item_next;
  logic              fire;

  logic [LimitW-1:0] debounce_limit;
  logic              alarm_sticky;
  logic              silenced;
  logic [LineW-1:0]  latched_channels;
  logic [LineW-1:0]  previous_lines;
  logic [PosW-1:0]   display_position;

  logic [LineW-1:0]  lines;
  logic [LineW-1:0]  rising;
  logic [LineW-1:0]  latched_next;
  logic [PosW-1:0]   pos_base;
  logic              sticky_next;
  logic              toggle;
  apan_disp_t        disp;

  // Handshake: process when the result register is free or draining
  assign fire          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OutDataW'(out_item);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= apan_in_t'(s_axis_tdata[InW-1:0]);
    end
  end

  // Alarm latching and sticky flag
  assign lines        = in_item.alarm_lines & LineMask;
  assign rising       = lines & ~previous_lines;
  assign latched_next = latched_channels | rising;
  assign pos_base     = (|rising) ? '0 : display_position;
  assign sticky_next  = alarm_sticky || (|lines);

  apan_display u_display (
    .latched (latched_next),
    .pos     (pos_base),
    .sel     (disp)
  );

  apan_debounce u_debounce (
    .clk          (clk),
    .rst          (rst),
    .en           (fire),
    .button_level (in_item.button_level),
    .ms_tick      (in_item.ms_tick),
    .limit        (debounce_limit),
    .toggle       (toggle)
  );

  // Result formed with the silence state before this sample's toggle
  always_comb begin
    out_item_next                     = '0;
    out_item_next.relay_on            = sticky_next && !silenced;
    out_item_next.red_led             = sticky_next;
    out_item_next.yellow_led          = !silenced;
    out_item_next.display_update      = in_item.display_tick;
    if (in_item.display_tick && disp.has_channel) begin
      out_item_next.display_has_channel = 1'b1;
      out_item_next.display_silent_tag  = silenced;
      out_item_next.display_channel     = disp.channel;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= out_item_next;
    end
  end

  // Panel state
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_sticky     <= 1'b0;
      silenced         <= 1'b0;
      latched_channels <= '0;
      previous_lines   <= '0;
      display_position <= '0;
    end else if (fire) begin
      alarm_sticky     <= sticky_next;
      silenced         <= silenced ^ toggle;
      latched_channels <= latched_next;
      previous_lines   <= lines;
      if (in_item.display_tick && disp.has_channel) begin
        display_position <= disp.pos_next;
      end else begin
        display_position <= pos_base;
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_limit <= DebounceLimitReset;
    end else if (cfg_wen) begin
      debounce_limit <= cfg_wdata;
    end
  end

endmodule : alarm_annunciator_panel
`default_nettype wire
